/* src/rpt_pkg.sv */
// ----------------------------------------------------------------------------
// rpt_pkg: shared definitions of the readout position tracker
// Field widths, reset values, register indexes, direction codes and the
// quadrature knob step decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rpt_pkg;

   // Default values of the top-level parameters.
   localparam int SLOT_COUNT_DEF   = 9;
   localparam int COUNTER_BITS_DEF = 4;

   // Field widths.
   localparam int POS_W    = 31;
   localparam int STEP_W   = 20;
   localparam int DIST_W   = 30;
   localparam int CONF_W   = 4;
   localparam int COUNT_W  = 4;
   localparam int PHASE_W  = 2;
   localparam int SLOT_W   = 4;
   localparam int DIR_W    = 2;
   localparam int MASK_W   = 10;
   localparam int SETTLE_W = 8;

   // Configuration bus.
   localparam int APB_AW = 4;
   localparam int APB_DW = 32;

   // Position limit and register reset values.
   localparam int POS_LIMIT     = 999999999;
   localparam int STEP_RESET    = 1;
   localparam int DIST_RESET    = 5000000;
   localparam int CONFIRM_RESET = 3;

   typedef enum logic [DIR_W-1:0] {
      DIR_MINUS   = 2'd0,
      DIR_PLUS    = 2'd1,
      DIR_UNKNOWN = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      REG_STEP_SIZE      = 2'd0,
      REG_ALARM_DISTANCE = 2'd1,
      REG_CONFIRM_TICKS  = 2'd2
   } reg_type;

   typedef enum logic [1:0] {
      KNOB_HOLD = 2'd0,
      KNOB_UP   = 2'd1,
      KNOB_DOWN = 2'd2
   } knob_type;

   // Decodes the older phase, the newer phase and the current phase into a
   // knob step. Only eight of the phase sequences move; all others hold.
   function automatic knob_type knob_decode(input logic [PHASE_W-1:0] older,
                                            input logic [PHASE_W-1:0] newer,
                                            input logic [PHASE_W-1:0] now);
      knob_type step;
      step = KNOB_HOLD;
      unique case ({older, newer, now})
         6'b111000, 6'b000111, 6'b010011, 6'b101100: step = KNOB_DOWN;
         6'b110100, 6'b001011, 6'b100011, 6'b011100: step = KNOB_UP;
         default: step = KNOB_HOLD;
      endcase
      return step;
   endfunction

endpackage

`default_nettype wire

/* src/rpt_channels.sv */
// ----------------------------------------------------------------------------
// rpt_channels: word channels of the readout position tracker
// Valid/ready channels for the event words and the result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpt_req_if;
   import rpt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 command;
   logic [COUNT_W-1:0]   count_value;
   logic [PHASE_W-1:0]   knob_phase;
   logic                 button_pressed;

   modport source (output valid, command, count_value, knob_phase, button_pressed,
                   input ready);
   modport sink   (input valid, command, count_value, knob_phase, button_pressed,
                   output ready);
endinterface

interface rpt_rsp_if;
   import rpt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [POS_W-1:0]   position;
   logic [SLOT_W-1:0]         selected_slot;
   logic signed [POS_W-1:0]   shown_value;
   logic [DIR_W-1:0]          shown_direction;
   logic [MASK_W-1:0]         alarm_mask;
   logic                      buzzer_on;

   modport source (output valid, position, selected_slot, shown_value, shown_direction,
                   alarm_mask, buzzer_on, input ready);
   modport sink   (input valid, position, selected_slot, shown_value, shown_direction,
                   alarm_mask, buzzer_on, output ready);
endinterface

`default_nettype wire

/* src/readout_position_tracker.sv */
// ----------------------------------------------------------------------------
// readout_position_tracker: position counter of a linear digital readout
// Tracks the live position from scale counter words, handles the slot knob
// and the store/zero button, and reports slot proximity alarms.
// ----------------------------------------------------------------------------
//
//   Port group   Direction  Handshake           Word
//   req_ch       in         valid/ready         command, count, knob, button
//   rsp_ch       out        valid/ready         position, slot, shown, alarms
//   APB (p*)     in/out     psel/penable/pready step size, alarm distance,
//                                               confirm ticks
//
// A moving count word passes the count, multiply, move, scan and done states;
// an unchanged count skips multiply and move, and a tick word passes the tick,
// scan and done states. The steps are set by the one shared adder: it runs a
// shift-add multiply, one bit a cycle, and then one alarm compare per stored
// slot. Reset is synchronous and active high and puts all but the working and
// result payload, including the slots, back to its initial value at once. The
// result sits in an output register, so a new word is taken while a stalled
// result waits; only a finished second result waits for the register to free.
//
`default_nettype none

module readout_position_tracker #(
   parameter int SLOT_COUNT   = rpt_pkg::SLOT_COUNT_DEF,
   parameter int COUNTER_BITS = rpt_pkg::COUNTER_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   rpt_req_if.sink                     req_ch,
   rpt_rsp_if.source                   rsp_ch,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rpt_pkg::APB_AW-1:0]  paddr,
   input  logic [rpt_pkg::APB_DW-1:0]  pwdata,
   output logic [rpt_pkg::APB_DW-1:0]  prdata,
   output logic                        pready
);
   import rpt_pkg::*;

   localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CB      = COUNTER_BITS;
   localparam int RD_W    = (CB > COUNT_W) ? CB : COUNT_W;
   localparam int PROD_W  = CB + STEP_W;
   localparam int ALU_W   = ((POS_W > PROD_W) ? POS_W : PROD_W) + 2;
   localparam int EXT_W   = ALU_W - POS_W;
   localparam int MCNT_W  = $clog2(CB);

   localparam logic [CB-1:0]           HALF      = {1'b1, {(CB-1){1'b0}}};
   localparam logic [MCNT_W-1:0]       MCNT_LAST = MCNT_W'(CB - 1);
   localparam logic [SLOT_AW-1:0]      SLOT_LAST = SLOT_AW'(SLOT_COUNT - 1);
   localparam logic [SLOT_W-1:0]       SLOT_MAX  = SLOT_W'(SLOT_COUNT);
   localparam logic signed [ALU_W-1:0] LIM_HI    = ALU_W'(POS_LIMIT);
   localparam logic signed [ALU_W-1:0] LIM_LO    = -LIM_HI;
   localparam logic [SETTLE_W-1:0]     SETTLE_MAX = '1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_COUNT = 7'b0000010,
      ST_MUL   = 7'b0000100,
      ST_MOVE  = 7'b0001000,
      ST_TICK  = 7'b0010000,
      ST_SCAN  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   // Control and architectural state.
   state_type                state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [DIST_W-1:0]        dist_ff, dist_in;
   logic [CONF_W-1:0]        confirm_ff, confirm_in;
   logic signed [POS_W-1:0]  live_pos_ff, live_pos_in;
   dir_type                  live_dir_ff, live_dir_in;
   logic signed [POS_W-1:0]  slot_val_ff [SLOT_COUNT];
   logic signed [POS_W-1:0]  slot_val_in [SLOT_COUNT];
   dir_type                  slot_dir_ff [SLOT_COUNT];
   dir_type                  slot_dir_in [SLOT_COUNT];
   logic [CB-1:0]            last_count_ff, last_count_in;
   logic [SLOT_W-1:0]        chosen_ff, chosen_in;
   logic [PHASE_W-1:0]       hist0_ff, hist0_in;
   logic [PHASE_W-1:0]       hist1_ff, hist1_in;
   logic [SETTLE_W-1:0]      settle_ff, settle_in;
   logic                     fault_ff, fault_in;
   logic [MCNT_W-1:0]        mcnt_ff, mcnt_in;
   logic [SLOT_AW-1:0]       scan_ff, scan_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Working and result payload.
   logic [COUNT_W-1:0]       count_word_ff, count_word_in;
   logic [PHASE_W-1:0]       phase_word_ff, phase_word_in;
   logic                     button_ff, button_in;
   logic [CB-1:0]            mult_ff, mult_in;
   dir_type                  move_dir_ff, move_dir_in;
   logic [PROD_W-1:0]        acc_ff, acc_in;
   logic [MASK_W-1:0]        mask_ff, mask_in;
   logic signed [POS_W-1:0]  shown_val_ff, shown_val_in;
   dir_type                  shown_dir_ff, shown_dir_in;
   logic signed [POS_W-1:0]  out_pos_ff, out_pos_in;
   logic [SLOT_W-1:0]        out_slot_ff, out_slot_in;
   logic signed [POS_W-1:0]  out_shown_ff, out_shown_in;
   logic [DIR_W-1:0]         out_dir_ff, out_dir_in;
   logic [MASK_W-1:0]        out_mask_ff, out_mask_in;

   // Shared adder.
   logic [ALU_W-1:0]         alu_a;
   logic [ALU_W-1:0]         alu_b;
   logic                     alu_sub;
   logic signed [ALU_W-1:0]  alu_sum;

   // Helpers.
   logic [RD_W-1:0]          rd_ext;
   logic [CB-1:0]            reading;
   logic [CB-1:0]            d_up;
   logic [CB-1:0]            d_dn;
   logic [CB-1:0]            diff;
   dir_type                  diff_dir;
   logic signed [POS_W-1:0]  slot_rd;
   dir_type                  slot_rd_dir;
   logic signed [ALU_W-1:0]  live_ext;
   logic signed [ALU_W-1:0]  slot_ext;
   logic signed [ALU_W-1:0]  dist_ext;
   logic                     gap_hit;
   logic [SLOT_W-1:0]        scan_slot;
   logic [SLOT_AW-1:0]       wr_idx;
   logic                     cfg_write;
   logic                     req_take;
   logic                     rsp_load;
   knob_type                 knob_step;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && (state_ff == ST_IDLE);
   assign rsp_load     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   // Shortest wrapping distance between the new reading and the last one.
   // Going up reads as minus travel unless the wrap the other way is shorter.
   assign rd_ext  = RD_W'(count_word_ff);
   assign reading = rd_ext[CB-1:0];
   assign d_up    = reading - last_count_ff;
   assign d_dn    = last_count_ff - reading;

   always_comb begin
      if (reading > last_count_ff) begin
         if (d_up > HALF) begin
            diff     = d_dn;
            diff_dir = DIR_PLUS;
         end else begin
            diff     = d_up;
            diff_dir = DIR_MINUS;
         end
      end else begin
         if (d_dn > HALF) begin
            diff     = d_up;
            diff_dir = DIR_MINUS;
         end else begin
            diff     = d_dn;
            diff_dir = DIR_PLUS;
         end
      end
   end

   // Slot read for the alarm scan, and the gap taken in the direction that
   // the slot was approached from, so both cases compare 0 < gap < distance.
   assign slot_rd     = slot_val_ff[scan_ff];
   assign slot_rd_dir = slot_dir_ff[scan_ff];
   assign live_ext    = {{EXT_W{live_pos_ff[POS_W-1]}}, live_pos_ff};
   assign slot_ext    = {{EXT_W{slot_rd[POS_W-1]}}, slot_rd};
   assign dist_ext    = $signed(ALU_W'(dist_ff));
   assign scan_slot   = SLOT_W'(scan_ff) + SLOT_W'(1);
   assign wr_idx      = SLOT_AW'(chosen_ff - SLOT_W'(1));

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         ST_MUL: begin
            alu_a = ALU_W'({acc_ff, 1'b0});
            alu_b = mult_ff[CB-1] ? ALU_W'(step_ff) : '0;
         end
         ST_MOVE: begin
            alu_a   = live_ext;
            alu_b   = ALU_W'(acc_ff);
            alu_sub = (move_dir_ff == DIR_MINUS);
         end
         ST_SCAN: begin
            alu_sub = 1'b1;
            if (slot_rd_dir == DIR_MINUS) begin
               alu_a = live_ext;
               alu_b = slot_ext;
            end else begin
               alu_a = slot_ext;
               alu_b = live_ext;
            end
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   assign alu_sum = $signed(alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub));

   assign gap_hit = ((slot_rd_dir == DIR_MINUS) || (slot_rd_dir == DIR_PLUS))
                    && !alu_sum[ALU_W-1] && (alu_sum != '0) && (alu_sum < dist_ext);

   assign knob_step = knob_decode(hist1_ff, hist0_ff, phase_word_ff);

   // Next-state logic.
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      dist_in       = dist_ff;
      confirm_in    = confirm_ff;
      live_pos_in   = live_pos_ff;
      live_dir_in   = live_dir_ff;
      slot_val_in   = slot_val_ff;
      slot_dir_in   = slot_dir_ff;
      last_count_in = last_count_ff;
      chosen_in     = chosen_ff;
      hist0_in      = hist0_ff;
      hist1_in      = hist1_ff;
      settle_in     = settle_ff;
      fault_in      = fault_ff;
      mcnt_in       = mcnt_ff;
      scan_in       = scan_ff;
      rsp_valid_in  = rsp_valid_ff;
      count_word_in = count_word_ff;
      phase_word_in = phase_word_ff;
      button_in     = button_ff;
      mult_in       = mult_ff;
      move_dir_in   = move_dir_ff;
      acc_in        = acc_ff;
      mask_in       = mask_ff;
      shown_val_in  = shown_val_ff;
      shown_dir_in  = shown_dir_ff;
      out_pos_in    = out_pos_ff;
      out_slot_in   = out_slot_ff;
      out_shown_in  = out_shown_ff;
      out_dir_in    = out_dir_ff;
      out_mask_in   = out_mask_ff;

      if (cfg_write) begin
         unique case (reg_type'(paddr[3:2]))
            REG_STEP_SIZE:      step_in    = pwdata[STEP_W-1:0];
            REG_ALARM_DISTANCE: dist_in    = pwdata[DIST_W-1:0];
            REG_CONFIRM_TICKS:  confirm_in = pwdata[CONF_W-1:0];
            default:            step_in    = step_ff;
         endcase
      end

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               count_word_in = req_ch.count_value;
               phase_word_in = req_ch.knob_phase;
               button_in     = req_ch.button_pressed;
               scan_in       = '0;
               mask_in       = '0;
               state_in      = req_ch.command ? ST_TICK : ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (reading == last_count_ff) begin
               state_in = ST_SCAN;
            end else begin
               if (diff == HALF) begin
                  fault_in = 1'b1;
               end
               last_count_in = reading;
               live_dir_in   = diff_dir;
               move_dir_in   = diff_dir;
               mult_in       = diff;
               acc_in        = '0;
               mcnt_in       = '0;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            // Shift-add multiply, most significant bit of the difference first.
            acc_in  = alu_sum[PROD_W-1:0];
            mult_in = {mult_ff[CB-2:0], 1'b0};
            mcnt_in = mcnt_ff + MCNT_W'(1);
            if (mcnt_ff == MCNT_LAST) begin
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            if (alu_sum > LIM_HI) begin
               live_pos_in = LIM_HI[POS_W-1:0];
            end else if (alu_sum < LIM_LO) begin
               live_pos_in = LIM_LO[POS_W-1:0];
            end else begin
               live_pos_in = alu_sum[POS_W-1:0];
            end
            state_in = ST_SCAN;
         end
         ST_TICK: begin
            // The button acts on the slot chosen before this tick's knob step.
            if (button_ff) begin
               if (chosen_ff == '0) begin
                  live_pos_in = '0;
                  live_dir_in = DIR_UNKNOWN;
               end else begin
                  slot_val_in[wr_idx] = live_pos_ff;
                  slot_dir_in[wr_idx] = live_dir_ff;
               end
            end
            if ((phase_word_ff != hist0_ff) && (phase_word_ff != hist1_ff)) begin
               if (settle_ff != SETTLE_MAX) begin
                  settle_in = settle_ff + SETTLE_W'(1);
               end
            end else begin
               settle_in = '0;
            end
            if (settle_in > SETTLE_W'(confirm_ff)) begin
               case (knob_step)
                  KNOB_UP: begin
                     chosen_in = (chosen_ff >= SLOT_MAX) ? '0 : chosen_ff + SLOT_W'(1);
                  end
                  KNOB_DOWN: begin
                     chosen_in = (chosen_ff == '0) ? SLOT_MAX : chosen_ff - SLOT_W'(1);
                  end
                  default: begin
                     chosen_in = chosen_ff;
                  end
               endcase
               hist1_in = hist0_ff;
               hist0_in = phase_word_ff;
            end
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            for (int b = 1; b < MASK_W; b++) begin
               if (gap_hit && (scan_slot == SLOT_W'(b))) begin
                  mask_in[b] = 1'b1;
               end
            end
            if (scan_slot == chosen_ff) begin
               shown_val_in = slot_rd;
               shown_dir_in = slot_rd_dir;
            end
            scan_in = scan_ff + SLOT_AW'(1);
            if (scan_ff == SLOT_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               out_pos_in   = live_pos_ff;
               out_slot_in  = chosen_ff;
               out_mask_in  = {mask_ff[MASK_W-1:1], fault_ff};
               if (chosen_ff == '0) begin
                  out_shown_in = live_pos_ff;
                  out_dir_in   = live_dir_ff;
               end else begin
                  out_shown_in = shown_val_ff;
                  out_dir_in   = shown_dir_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= STEP_W'(STEP_RESET);
         dist_ff       <= DIST_W'(DIST_RESET);
         confirm_ff    <= CONF_W'(CONFIRM_RESET);
         live_pos_ff   <= '0;
         live_dir_ff   <= DIR_UNKNOWN;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_val_ff[i] <= '0;
            slot_dir_ff[i] <= DIR_UNKNOWN;
         end
         last_count_ff <= '0;
         chosen_ff     <= '0;
         hist0_ff      <= '0;
         hist1_ff      <= '0;
         settle_ff     <= '0;
         fault_ff      <= 1'b0;
         mcnt_ff       <= '0;
         scan_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         dist_ff       <= dist_in;
         confirm_ff    <= confirm_in;
         live_pos_ff   <= live_pos_in;
         live_dir_ff   <= live_dir_in;
         slot_val_ff   <= slot_val_in;
         slot_dir_ff   <= slot_dir_in;
         last_count_ff <= last_count_in;
         chosen_ff     <= chosen_in;
         hist0_ff      <= hist0_in;
         hist1_ff      <= hist1_in;
         settle_ff     <= settle_in;
         fault_ff      <= fault_in;
         mcnt_ff       <= mcnt_in;
         scan_ff       <= scan_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_word_ff <= count_word_in;
      phase_word_ff <= phase_word_in;
      button_ff     <= button_in;
      mult_ff       <= mult_in;
      move_dir_ff   <= move_dir_in;
      acc_ff        <= acc_in;
      mask_ff       <= mask_in;
      shown_val_ff  <= shown_val_in;
      shown_dir_ff  <= shown_dir_in;
      out_pos_ff    <= out_pos_in;
      out_slot_ff   <= out_slot_in;
      out_shown_ff  <= out_shown_in;
      out_dir_ff    <= out_dir_in;
      out_mask_ff   <= out_mask_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.position        = out_pos_ff;
   assign rsp_ch.selected_slot   = out_slot_ff;
   assign rsp_ch.shown_value     = out_shown_ff;
   assign rsp_ch.shown_direction = out_dir_ff;
   assign rsp_ch.alarm_mask      = out_mask_ff;
   assign rsp_ch.buzzer_on       = |out_mask_ff;

   always_comb begin
      prdata = '0;
      unique case (reg_type'(paddr[3:2]))
         REG_STEP_SIZE:      prdata = APB_DW'(step_ff);
         REG_ALARM_DISTANCE: prdata = APB_DW'(dist_ff);
         REG_CONFIRM_TICKS:  prdata = APB_DW'(confirm_ff);
         default:            prdata = '0;
      endcase
   end

endmodule

`default_nettype wire
